>>> src/sequential_list_table_macros.svh
// ---------------------------------------------------------------------------
// sequential_list_table assertion macros
// immediate-cycle and next-cycle implication checks on clk and rst_n
// ---------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_TABLE_MACROS_SVH
`define SEQUENTIAL_LIST_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define SLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequential_list_table check failed");
`define SLT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequential_list_table check failed");
`else
`define SLT_ASSERT_NOW(label, ante, cons)
`define SLT_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> src/slt_pkg.sv
// ---------------------------------------------------------------------------
// slt_pkg
// shared types and constants of the ordered list table
// ---------------------------------------------------------------------------
package slt_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int FIDX_W   = 5;
  localparam int LEN_W    = 6;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic [1:0]               op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [FIDX_W-1:0]        found_index;
    logic signed [DATA_W-1:0] item_value;
    logic                     item_valid;
    logic                     last;
    logic [LEN_W-1:0]         list_length;
  } out_item_t;

  typedef struct packed {
    cell_cmd_t                cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         count;
    logic [IDX_W-1:0]         last_idx;
  } cell_ctl_t;

endpackage

>>> src/slt_cell.sv
// ---------------------------------------------------------------------------
// slt_cell
// one list entry: shifts up on insert, down on delete, rotates on dump
// ---------------------------------------------------------------------------
module slt_cell (
  input  logic                             clk,
  input  logic [slt_pkg::IDX_W-1:0]        cell_idx,
  input  slt_pkg::cell_ctl_t               ctl,
  input  logic signed [slt_pkg::DATA_W-1:0] left_val,
  input  logic signed [slt_pkg::DATA_W-1:0] right_val,
  input  logic signed [slt_pkg::DATA_W-1:0] wrap_val,
  output logic signed [slt_pkg::DATA_W-1:0] entry_val,
  output logic                             match
);
  import slt_pkg::*;

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;
  logic [POS_W-1:0]         idx_p;
  logic [CNT_W-1:0]         idx_c;

  assign idx_p = POS_W'(cell_idx);
  assign idx_c = CNT_W'(cell_idx);

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.cmd)
      CELL_INSERT: begin
        if (idx_p == ctl.pos) begin
          entry_nxt = ctl.data;
        end else if (idx_p > ctl.pos) begin
          entry_nxt = left_val;
        end
      end
      CELL_DELETE: begin
        if (idx_p >= ctl.pos) begin
          entry_nxt = right_val;
        end
      end
      CELL_ROTATE: begin
        if (cell_idx == ctl.last_idx) begin
          entry_nxt = wrap_val;
        end else if (cell_idx < ctl.last_idx) begin
          entry_nxt = right_val;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_val = entry_r;
  assign match     = (entry_r == ctl.data) && (idx_c < ctl.count);

endmodule

>>> src/sequential_list_table.sv
// ---------------------------------------------------------------------------
// sequential_list_table
// ordered list of signed 32-bit entries with insert, delete, search and dump
// ---------------------------------------------------------------------------
// The list lives in a row of 32 entry cells; every cell shifts, rotates or
// compares in the same cycle, so insert, delete and search use the accept
// cycle, where the row shifts and all compares are captured, and a response
// state that encodes the lowest match into the output register. A dump reads
// one entry per cycle from cell 0 while the output register is free, as the
// occupied cells rotate back into place; an empty dump gives one response
// item. A new item is taken once the response or the last dumped entry
// has entered the output register, which holds it until the far side takes
// it. No clearing pass follows reset; entries are only read after written.
module sequential_list_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  slt_pkg::in_item_t  in_payload,
  output logic               out_valid,
  input  logic               out_stall,
  output slt_pkg::out_item_t out_payload
);
  import slt_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [CAPACITY-1:0] match_r, match_nxt;
  logic [IDX_W-1:0]    dcnt_r, dcnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_payload_r, out_payload_nxt;

  logic                     in_acc;
  logic                     slot_free;
  logic                     ins_bad, ins_full, del_bad;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         enc_idx;
  logic                     dump_last;
  cell_ctl_t                cell_ctl;
  logic signed [DATA_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]      match_w;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign dump_last = (dcnt_r == last_idx);

  assign ins_bad  = (in_payload.position > POS_W'(count_r));
  assign ins_full = (count_r == CNT_W'(CAPACITY));
  assign del_bad  = (in_payload.position >= POS_W'(count_r));

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = entry_w[g];
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    slt_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(g)),
      .ctl       (cell_ctl),
      .left_val  (left_w),
      .right_val (right_w),
      .wrap_val  (entry_w[0]),
      .entry_val (entry_w[g]),
      .match     (match_w[g])
    );
  end

  // lowest match
  always_comb begin
    enc_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        enc_idx = IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_payload.op == OP_DUMP && count_r != '0) begin
            state_nxt = S_DUMP;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (slot_free && dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    count_nxt       = count_r;
    op_nxt          = op_r;
    status_nxt      = status_r;
    match_nxt       = match_r;
    dcnt_nxt        = dcnt_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_payload_nxt = out_payload_r;
    cell_ctl.cmd      = CELL_HOLD;
    cell_ctl.pos      = in_payload.position;
    cell_ctl.data     = in_payload.data_value;
    cell_ctl.count    = count_r;
    cell_ctl.last_idx = last_idx;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_payload.op;
          status_nxt = ST_OK;
          dcnt_nxt   = '0;
          match_nxt  = match_w;
          case (in_payload.op)
            OP_INSERT: begin
              if (ins_bad) begin
                status_nxt = ST_BAD_POS;
              end else if (ins_full) begin
                status_nxt = ST_FULL;
              end else begin
                cell_ctl.cmd = CELL_INSERT;
                count_nxt    = count_r + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (del_bad) begin
                status_nxt = ST_BAD_POS;
              end else begin
                cell_ctl.cmd = CELL_DELETE;
                count_nxt    = count_r - CNT_W'(1);
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt               = 1'b1;
          out_payload_nxt.status      = status_r;
          out_payload_nxt.found_index = '0;
          out_payload_nxt.item_value  = '0;
          out_payload_nxt.item_valid  = 1'b0;
          out_payload_nxt.last        = 1'b1;
          out_payload_nxt.list_length = LEN_W'(count_r);
          if (op_r == OP_SEARCH) begin
            if (|match_r) begin
              out_payload_nxt.status      = ST_OK;
              out_payload_nxt.found_index = FIDX_W'(enc_idx);
            end else begin
              out_payload_nxt.status = ST_NOT_FOUND;
            end
          end
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          cell_ctl.cmd                = CELL_ROTATE;
          dcnt_nxt                    = dcnt_r + IDX_W'(1);
          out_valid_nxt               = 1'b1;
          out_payload_nxt.status      = ST_OK;
          out_payload_nxt.found_index = '0;
          out_payload_nxt.item_value  = entry_w[0];
          out_payload_nxt.item_valid  = 1'b1;
          out_payload_nxt.last        = dump_last;
          out_payload_nxt.list_length = LEN_W'(count_r);
        end
      end
      default: cell_ctl.cmd = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    status_r      <= status_nxt;
    match_r       <= match_nxt;
    dcnt_r        <= dcnt_nxt;
    out_payload_r <= out_payload_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

`include "sequential_list_table_macros.svh"

  `SLT_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SLT_ASSERT_NXT(a_insert_grows, cell_ctl.cmd == CELL_INSERT, count_r == $past(count_r) + 1'b1)
  `SLT_ASSERT_NXT(a_delete_shrinks, cell_ctl.cmd == CELL_DELETE, count_r == $past(count_r) - 1'b1)
  `SLT_ASSERT_NOW(a_dump_nonempty, state_r == S_DUMP, count_r != '0)
  `SLT_ASSERT_NOW(a_single_is_last, out_valid_r && !out_payload_r.item_valid, out_payload_r.last)

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sequential_list_table ordered list
// Drives a directed table of inserts, deletes, searches and dumps through the
// valid/stall input channel (empty, full and bad-position cases with typed
// results), then about 320 random operations in fill, drain and mixed
// phases. A behavioral list tracks every accepted item and queues the
// expected result items, and each result taken from the output channel is
// compared field by field. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int RANDOM_ITEMS = 320;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    op_t         op;
    logic [5:0]  pos;
    logic [31:0] val;
    int          reps;
    bit          typed;
    status_t     st;
    logic [5:0]  len;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_payload = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_payload;

  logic signed [DATA_W-1:0] list_entries [CAPACITY];
  int                       list_count = 0;
  out_item_t                expected_results [$];
  int                       err_count = 0;
  int                       cycle_count = 0;
  bit                       quiet = 1'b0;
  int                       stall_run = 0;
  dir_row_t                 directed [$];
  in_item_t                 stim;
  out_item_t                typed_want;
  out_item_t                got_want;
  int                       seg_kind;

  sequential_list_table u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic dir_row_t mk_row(op_t op, int pos, logic [31:0] val, int reps,
                                      int typed, status_t st, int len);
    dir_row_t r;
    r.op    = op;
    r.pos   = pos[5:0];
    r.val   = val;
    r.reps  = reps;
    r.typed = (typed != 0);
    r.st    = st;
    r.len   = len[5:0];
    return r;
  endfunction

  // list behavior: updates the list and returns the result items of one item
  function automatic void apply_list_op(input in_item_t it, ref out_item_t res[$]);
    out_item_t r;
    bit        hit;
    res.delete();
    r = '0;
    r.last = 1'b1;
    hit = 1'b0;
    case (op_t'(it.op))
      OP_INSERT: begin
        if (it.position > list_count) begin
          r.status = ST_BAD_POS;
        end else if (list_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = list_count; i > it.position; i--) list_entries[i] = list_entries[i-1];
          list_entries[IDX_W'(it.position)] = it.data_value;
          list_count++;
          r.status = ST_OK;
        end
      end
      OP_DELETE: begin
        if (it.position >= list_count) begin
          r.status = ST_BAD_POS;
        end else begin
          for (int i = it.position + 1; i < list_count; i++) list_entries[i-1] = list_entries[i];
          list_count--;
          r.status = ST_OK;
        end
      end
      OP_SEARCH: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < list_count; i++) begin
          if (!hit && list_entries[i] == it.data_value) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.found_index = i[FIDX_W-1:0];
          end
        end
      end
      default: begin
        r.status = ST_OK;
        if (list_count != 0) begin
          r.list_length = list_count[LEN_W-1:0];
          for (int i = 0; i < list_count; i++) begin
            r.item_value = list_entries[i];
            r.item_valid = 1'b1;
            r.last = (i == list_count - 1);
            res.push_back(r);
          end
          return;
        end
      end
    endcase
    r.list_length = list_count[LEN_W-1:0];
    res.push_back(r);
  endfunction

  function automatic int unsigned idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic in_item_t random_list_op(int seg);
    in_item_t it;
    int       roll;
    int       ins_w;
    int       del_w;
    int       srch_w;
    case (seg)
      1:       begin ins_w = 80; del_w = 85; srch_w = 95; end
      2:       begin ins_w = 10; del_w = 85; srch_w = 95; end
      default: begin ins_w = 35; del_w = 60; srch_w = 90; end
    endcase
    it = '0;
    roll = $urandom_range(0, 99);
    if (roll < ins_w) it.op = OP_INSERT;
    else if (roll < del_w) it.op = OP_DELETE;
    else if (roll < srch_w) it.op = OP_SEARCH;
    else it.op = OP_DUMP;
    it.position = POS_W'($urandom_range(0, CAPACITY));
    if ($urandom_range(0, 99) < 85) begin
      if (it.op == OP_INSERT) begin
        it.position = POS_W'($urandom_range(0, list_count));
      end else if (it.op == OP_DELETE && list_count > 0) begin
        it.position = POS_W'($urandom_range(0, list_count - 1));
      end
    end
    case ($urandom_range(0, 9))
      0:       it.data_value = 32'sh8000_0000;
      1:       it.data_value = 32'sh7fff_ffff;
      2:       it.data_value = -32'sd1;
      3:       it.data_value = 32'sd0;
      4, 5:    it.data_value = $urandom_range(0, 7);
      default: it.data_value = $urandom;
    endcase
    if (it.op == OP_SEARCH && list_count > 0 && $urandom_range(0, 99) < 60)
      it.data_value = list_entries[IDX_W'($urandom_range(0, list_count - 1))];
    return it;
  endfunction

  function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
    err_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endfunction

  function automatic void check_item(out_item_t want, out_item_t got);
    if (got.status !== want.status)
      report_field("status", 32'(want.status), 32'(got.status));
    if (got.found_index !== want.found_index)
      report_field("found_index", 32'(want.found_index), 32'(got.found_index));
    if (got.item_value !== want.item_value)
      report_field("item_value", want.item_value, got.item_value);
    if (got.item_valid !== want.item_valid)
      report_field("item_valid", 32'(want.item_valid), 32'(got.item_valid));
    if (got.last !== want.last) report_field("last", 32'(want.last), 32'(got.last));
    if (got.list_length !== want.list_length)
      report_field("list_length", 32'(want.list_length), 32'(got.list_length));
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t res [$];
    int unsigned gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_payload <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    apply_list_op(it, res);
    if (typed) expected_results.push_back(want);
    else foreach (res[i]) expected_results.push_back(res[i]);
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // result channel check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected item, expected none, actual %p", $time, out_payload);
      end else begin
        got_want = expected_results.pop_front();
        check_item(got_want, out_payload);
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin out_stall <= 1'b0; stall_run = $urandom_range(0, 2); end
        4, 5, 6:    begin out_stall <= 1'b1; stall_run = $urandom_range(0, 2); end
        7:          begin out_stall <= 1'b1; stall_run = $urandom_range(8, 25); end
        default:    begin out_stall <= 1'b0; stall_run = $urandom_range(20, 60); end
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    directed = '{
      mk_row(OP_DUMP,    0, 32'h0,         1,  1, ST_OK,        0),
      mk_row(OP_DELETE,  0, 32'h0,         1,  1, ST_BAD_POS,   0),
      mk_row(OP_SEARCH,  0, 32'h0,         1,  1, ST_NOT_FOUND, 0),
      mk_row(OP_INSERT,  1, 32'h5,         1,  1, ST_BAD_POS,   0),
      mk_row(OP_INSERT,  0, 32'h7fff_ffff, 1,  1, ST_OK,        1),
      mk_row(OP_INSERT,  1, 32'h8000_0000, 1,  1, ST_OK,        2),
      mk_row(OP_INSERT,  0, 32'hffff_ffff, 1,  1, ST_OK,        3),
      mk_row(OP_INSERT, 32, 32'h7,         1,  1, ST_BAD_POS,   3),
      mk_row(OP_SEARCH,  0, 32'h8000_0000, 1,  0, ST_OK,        0),
      mk_row(OP_SEARCH,  0, 32'hffff_ffff, 1,  0, ST_OK,        0),
      mk_row(OP_DUMP,    0, 32'h0,         1,  0, ST_OK,        0),
      mk_row(OP_INSERT,  3, 32'h0,         1,  0, ST_OK,        0),
      mk_row(OP_INSERT,  1, 32'hffff_ffff, 1,  0, ST_OK,        0),
      mk_row(OP_SEARCH,  0, 32'hffff_ffff, 1,  0, ST_OK,        0),
      mk_row(OP_DELETE,  4, 32'h0,         1,  0, ST_OK,        0),
      mk_row(OP_DELETE,  4, 32'h0,         1,  1, ST_BAD_POS,   4),
      mk_row(OP_DELETE,  0, 32'h0,         1,  0, ST_OK,        0),
      mk_row(OP_SEARCH,  0, 32'h0,         1,  1, ST_NOT_FOUND, 3),
      mk_row(OP_INSERT,  1, 32'h5a5a_a5a5, 29, 0, ST_OK,        0),
      mk_row(OP_INSERT, 32, 32'h0,         1,  1, ST_FULL,      32),
      mk_row(OP_INSERT,  0, 32'h0,         1,  1, ST_FULL,      32),
      mk_row(OP_DELETE, 32, 32'h0,         1,  1, ST_BAD_POS,   32),
      mk_row(OP_DUMP,    0, 32'h0,         1,  0, ST_OK,        0),
      mk_row(OP_SEARCH,  0, 32'h5a5a_a5a5, 1,  0, ST_OK,        0),
      mk_row(OP_DELETE, 31, 32'h0,         1,  0, ST_OK,        0),
      mk_row(OP_DELETE,  0, 32'h0,         31, 0, ST_OK,        0),
      mk_row(OP_DUMP,    0, 32'h0,         1,  1, ST_OK,        0)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[r]) begin
      for (int n = 0; n < directed[r].reps; n++) begin
        stim = '0;
        stim.op = directed[r].op;
        stim.position = directed[r].pos;
        stim.data_value = directed[r].val;
        typed_want = '0;
        typed_want.status = directed[r].st;
        typed_want.last = 1'b1;
        typed_want.list_length = directed[r].len;
        send_item(stim, directed[r].typed, typed_want);
      end
    end

    seg_kind = 0;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 40 == 0) begin
        seg_kind = $urandom_range(0, 2);
        quiet = ($urandom_range(0, 3) == 0);
      end
      // let the result channel run dry once mid-run
      if (k == RANDOM_ITEMS / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      stim = random_list_op(seg_kind);
      send_item(stim, 1'b0, typed_want);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
